/* rtl/core/plc_pkg.sv */
// ----------------------------------------------------------------------------
// plc_pkg: shared types for the positional insert/delete list
// Opcodes, status codes and the command that the controller broadcasts to
// every storage cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

    // data width of one list entry
    localparam int DATA_W = 32;

    // cell index width; covers DEPTH up to 64
    localparam int IDX_MAX_W = 6;

    // transaction opcodes
    typedef enum logic [1:0] {
        OP_DISPLAY = 2'd0,
        OP_INSERT  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_DELETE  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // per-cycle action of the cell chain
    typedef enum logic [2:0] {
        CELL_HOLD    = 3'd0,
        CELL_INSERT  = 3'd1,
        CELL_REPLACE = 3'd2,
        CELL_DELETE  = 3'd3,
        CELL_ROTATE  = 3'd4
    } cell_op_t;

    // command broadcast to all cells
    typedef struct packed {
        cell_op_t                   op;
        logic [IDX_MAX_W-1:0]       pos;    // target index
        logic [IDX_MAX_W-1:0]       wrap;   // last occupied index (rotate)
        logic signed [DATA_W-1:0]   value;  // value for insert / replace
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/plc_if.sv */
// ----------------------------------------------------------------------------
// plc_if: channel interfaces of the positional insert/delete list
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface plc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [3:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output position, output value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input value,
                    output ready);
endinterface

// result channel
interface plc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic [3:0]         out_position;
    logic [4:0]         count;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, output out_value, output out_position,
                    output count, output status, output last, input ready);
    modport sink   (input valid, input out_value, input out_position,
                    input count, input status, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/plc_cell.sv */
// ----------------------------------------------------------------------------
// plc_cell: one storage cell of the list chain
// Holds one entry; takes its left or right neighbor, the broadcast value or
// the list head according to the command and its own index.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_cell
    import plc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic                     clk,
    input  wire cell_cmd_t                cmd,
    input  wire logic signed [DATA_W-1:0] left,
    input  wire logic signed [DATA_W-1:0] right,
    input  wire logic signed [DATA_W-1:0] head,
    output logic signed [DATA_W-1:0]      data
);

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // next entry value
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (MY_IDX == cmd.pos)
                    data_next = cmd.value;
                else if (MY_IDX > cmd.pos)
                    data_next = left;
            end
            CELL_REPLACE:
            begin
                if (MY_IDX == cmd.pos)
                    data_next = cmd.value;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= cmd.pos)
                    data_next = right;
            end
            CELL_ROTATE:
            begin
                if (MY_IDX == cmd.wrap)
                    data_next = head;
                else if (MY_IDX < cmd.wrap)
                    data_next = right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/core/plc_ctrl.sv */
// ----------------------------------------------------------------------------
// plc_ctrl: controller of the positional insert/delete list
// Checks bounds, keeps the entry count, drives the cell chain and holds the
// result register; walks the list during display by rotating the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_ctrl
    import plc_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    plc_in_if.sink                        item,
    plc_out_if.source                     result,
    input  wire logic signed [DATA_W-1:0] head,
    output cell_cmd_t                     cmd
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = (CW > 4) ? CW : 4;
    localparam int CXW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic [3:0]        out_pos_reg, out_pos_next;
    logic [4:0]        out_count_reg, out_count_next;
    status_t           out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic              load;
    logic              show_step;
    logic              show_last;
    op_t               op;
    logic [PW-1:0]     pos_w;
    logic [PW-1:0]     cnt_w;
    logic [PW-1:0]     idx_w;
    logic [CXW-1:0]    count_x;
    logic              full;
    logic              empty;

    assign out_free    = !out_valid_reg || result.ready;
    assign item.ready  = (state_reg == S_IDLE) && out_free;
    assign accept      = item.valid && item.ready;
    assign op          = op_t'(item.opcode);
    assign pos_w       = PW'(item.position);
    assign cnt_w       = PW'(count_reg);
    assign idx_w       = PW'(idx_reg);
    assign full        = (count_reg == CW'(DEPTH));
    assign empty       = (count_reg == '0);
    assign show_step   = (state_reg == S_SHOW) && out_free;
    assign show_last   = (idx_reg == count_reg - CW'(1));
    assign count_x     = CXW'(count_next);

    // operation decode and result formation
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        load            = 1'b0;
        out_value_next  = '0;
        out_pos_next    = '0;
        out_status_next = STAT_OK;
        out_last_next   = 1'b1;
        cmd.op          = CELL_HOLD;
        cmd.pos         = IDX_MAX_W'(pos_w);
        cmd.wrap        = IDX_MAX_W'(count_reg - CW'(1));
        cmd.value       = item.value;

        if (show_step)
        begin
            // one entry per cycle if out_free; chain rotates next one to the head
            load           = 1'b1;
            out_value_next = head;
            out_pos_next   = idx_w[3:0];
            out_last_next  = show_last;
            cmd.op         = CELL_ROTATE;
            idx_next       = idx_reg + CW'(1);
            if (show_last)
                state_next = S_IDLE;
        end
        else if (accept)
        begin
            load = 1'b1;
            case (op)
                OP_DISPLAY:
                begin
                    if (empty)
                        out_status_next = STAT_EMPTY;
                    else
                    begin
                        load       = 1'b0;
                        idx_next   = '0;
                        state_next = S_SHOW;
                    end
                end
                OP_INSERT:
                begin
                    if (full)
                        out_status_next = STAT_FULL;
                    else if (pos_w > cnt_w)
                        out_status_next = STAT_RANGE;
                    else
                    begin
                        cmd.op     = CELL_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_REPLACE,
                OP_DELETE:
                begin
                    if (empty)
                        out_status_next = STAT_EMPTY;
                    else if (pos_w >= cnt_w)
                        out_status_next = STAT_RANGE;
                    else if (op == OP_REPLACE)
                        cmd.op = CELL_REPLACE;
                    else
                    begin
                        cmd.op     = CELL_DELETE;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end

        out_count_next = count_x[4:0];
        out_valid_next = load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg  <= out_value_next;
            out_pos_reg    <= out_pos_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_value    = out_value_reg;
    assign result.out_position = out_pos_reg;
    assign result.count        = out_count_reg;
    assign result.status       = out_status_reg;
    assign result.last         = out_last_reg;

`ifndef SYNTH
    // entry count stays within the chain
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // display index stays below the count
    a_show_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHOW) |-> (idx_reg < count_reg))
        else $error("display index out of range");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("result register overwritten while stalled");

    // the final display read-out returns the controller to idle
    a_show_end: assert property (@(posedge clk) disable iff (!rst_n)
        (show_step && show_last) |=> (state_reg == S_IDLE))
        else $error("display did not finish");

    // count never changes during display
    a_show_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHOW) |=> $stable(count_reg))
        else $error("count changed during display");
`endif

endmodule

`default_nettype wire

/* rtl/core/positional_insert_delete_list.sv */
// ----------------------------------------------------------------------------
// positional_insert_delete_list: ordered list with indexed insert/delete
// Top level: a controller and a chain of DEPTH storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   item   : request channel (valid/ready) with opcode, position, value.
//   result : result channel (valid/ready) with out_value, out_position,
//            count, status, last. Every request gives one or more results;
//            last marks the final one.
//   Insert, replace and delete are applied in a single step: all cells
//   shift in parallel, and the result is registered with the update.
//   Display of N entries gives N results, one entry per cycle while the
//   receiver takes them; the cell chain rotates once per read-out and is
//   back in order afterward. A request occupies the block until its
//   results are formed: a new request is taken once the result register
//   is free, and after a display only once its last read-out is formed.
//   Reset clears the entry count and the result valid; cell contents are
//   not cleared and are never read before being written.
//   When the receiver stalls, the result register holds its transaction
//   and no further request or display read-out proceeds.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list
    import plc_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    plc_in_if.sink    item,
    plc_out_if.source result
);

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] cell_data [DEPTH];

    // controller
    plc_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .head   (cell_data[0]),
        .cmd    (cmd)
    );

    // storage chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic signed [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        plc_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .left  (left_data),
            .right (right_data),
            .head  (cell_data[0]),
            .data  (cell_data[i])
        );
    end

endmodule

`default_nettype wire
